@@ rtl/quaternion_attitude_yaw_fusion_unit_defines.svh @@
// Assertion helpers for the attitude fusion block.
// Both expect signals named clock and reset in the calling scope.
`ifndef QUATERNION_ATTITUDE_YAW_FUSION_UNIT_DEFINES_SVH
`define QUATERNION_ATTITUDE_YAW_FUSION_UNIT_DEFINES_SVH

// Same-cycle implication.
`define QAYF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qayf: same-cycle check failed");

// Next-cycle implication.
`define QAYF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qayf: next-cycle check failed");

`endif

@@ rtl/qayf_pkg.sv @@
`default_nettype none

package qayf_pkg;

   localparam int ANGLE_ITERATIONS_DEF = 16;

   localparam int VEC_W      = 40;   // CORDIC vector width
   localparam int ANGLE_W    = 24;   // CORDIC angle, 1e-4 degree
   localparam int SQRT_IN_W  = 58;
   localparam int SQRT_OUT_W = 29;
   localparam int SQRT_STEPS = 29;

   localparam logic [15:0] PERIOD_RESET    = 16'd10;
   localparam logic [15:0] MAX_AGE_RESET   = 16'd5000;
   localparam logic [15:0] MIN_SPEED_RESET = 16'd500;
   localparam logic [14:0] DEADBAND_RESET  = 15'd150;
   localparam logic [15:0] GAIN_MIN_RESET  = 16'd3277;
   localparam logic [15:0] GAIN_MAX_RESET  = 16'd22938;

   typedef enum logic [1:0] {
      OP_GYRO  = 2'd0,
      OP_ACCEL = 2'd1,
      OP_QUAT  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      CSR_PERIOD    = 3'd0,
      CSR_MAX_AGE   = 3'd1,
      CSR_MIN_SPEED = 3'd2,
      CSR_DEADBAND  = 3'd3,
      CSR_GAIN_MIN  = 3'd4,
      CSR_GAIN_MAX  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ANG_ROLL,
      ANG_PITCH,
      ANG_YAW
   } angle_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GYRO,
      S_PROD,
      S_SQMUL,
      S_SQSTART,
      S_SQWAIT,
      S_ANG_START,
      S_ANG_WAIT,
      S_ANG_MUL,
      S_ANG_RND,
      S_GAIN_MUL,
      S_GAIN_Q,
      S_GAIN_CLAMP,
      S_CORR_MUL,
      S_CORR,
      S_EMIT
   } state_type;

   // atan(2^-i) in 1e-4 degree
   function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [4:0] idx);
      logic signed [ANGLE_W-1:0] res;
      unique case (idx)
         5'd0:  res = 24'sd450000;
         5'd1:  res = 24'sd265651;
         5'd2:  res = 24'sd140362;
         5'd3:  res = 24'sd71250;
         5'd4:  res = 24'sd35763;
         5'd5:  res = 24'sd17899;
         5'd6:  res = 24'sd8952;
         5'd7:  res = 24'sd4476;
         5'd8:  res = 24'sd2238;
         5'd9:  res = 24'sd1119;
         5'd10: res = 24'sd560;
         5'd11: res = 24'sd280;
         5'd12: res = 24'sd140;
         5'd13: res = 24'sd70;
         5'd14: res = 24'sd35;
         5'd15: res = 24'sd17;
         5'd16: res = 24'sd9;
         5'd17: res = 24'sd4;
         5'd18: res = 24'sd2;
         5'd19: res = 24'sd1;
         5'd20: res = 24'sd1;
         default: res = 24'sd0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/qayf_cordic.sv @@
`default_nettype none

module qayf_cordic #(
   parameter int ITERATIONS = qayf_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [qayf_pkg::VEC_W-1:0]     vec_y,
   input  logic signed [qayf_pkg::VEC_W-1:0]     vec_x,
   output logic                                  done,
   output logic signed [qayf_pkg::ANGLE_W-1:0]   angle
);

   localparam int CNT_W = $clog2(ITERATIONS);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [CNT_W-1:0]                    step_ff, step_in;
   logic signed [qayf_pkg::VEC_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [qayf_pkg::ANGLE_W-1:0] z_ff, z_in;
   logic signed [qayf_pkg::VEC_W-1:0]   shx, shy;
   logic signed [qayf_pkg::ANGLE_W-1:0] step_angle;
   logic                                last;

   assign shx        = x_ff >>> step_ff;
   assign shy        = y_ff >>> step_ff;
   assign step_angle = qayf_pkg::atan_step(5'(step_ff));
   assign last       = (step_ff == CNT_W'(ITERATIONS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         // fold the left half plane onto the right one
         if (vec_x < 0) begin
            x_in = -vec_x;
            y_in = -vec_y;
            z_in = (vec_y >= 0) ? 24'sd1800000 : -24'sd1800000;
         end else begin
            x_in = vec_x;
            y_in = vec_y;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + shy;
            y_in = y_ff - shx;
            z_in = z_ff + step_angle;
         end else begin
            x_in = x_ff - shy;
            y_in = y_ff + shx;
            z_in = z_ff - step_angle;
         end
         step_in = step_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

`default_nettype wire

@@ rtl/qayf_isqrt.sv @@
`default_nettype none

module qayf_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [qayf_pkg::SQRT_IN_W-1:0]     radicand,
   output logic                               done,
   output logic [qayf_pkg::SQRT_OUT_W-1:0]    root
);

   localparam int CNT_W = $clog2(qayf_pkg::SQRT_STEPS);

   logic                               busy_ff, done_ff;
   logic [CNT_W-1:0]                   cnt_ff;
   logic [qayf_pkg::SQRT_IN_W-1:0]     rad_ff;
   logic [30:0]                        rem_ff;
   logic [qayf_pkg::SQRT_OUT_W-1:0]    root_ff;
   logic [32:0]                        rem_sh, trial;
   logic                               fits;

   // one result bit per cycle, two radicand bits in
   assign rem_sh = {rem_ff, rad_ff[qayf_pkg::SQRT_IN_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(qayf_pkg::SQRT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fits ? 31'(rem_sh - trial) : rem_sh[30:0];
         root_ff <= {root_ff[qayf_pkg::SQRT_OUT_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ rtl/quaternion_attitude_yaw_fusion_unit.sv @@
// Attitude packet unit with GPS heading fusion.
// Input words (req_*) carry one sensor event: gyro, accel or quaternion.
// A word is taken when req_valid is high and req_stall low; req_stall is
// high while an event is being worked on. A quaternion word whose packet
// period has elapsed runs nine products, a 29-step square root and three
// CORDIC passes, all on one shared 32x32 multiplier, one root unit and one
// CORDIC unit; when the heading is pulled toward the GPS course, the gain
// products and a correction product follow on the same multiplier.
// Result words (rsp_*) sit in an output register; rsp_valid holds and the
// payload stays put while rsp_stall is high. New events are taken while a
// result waits, but a second packet waits in its last step until the
// first one is taken.
// Registers are written through the APB port (pready always high).
// Synchronous reset loads register defaults, clears gyro and accel caches
// and the last packet time, and drops any pending result.
`default_nettype none

module quaternion_attitude_yaw_fusion_unit #(
   parameter int ANGLE_ITERATIONS = qayf_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_val_w,
   input  logic signed [15:0] req_val_x,
   input  logic signed [15:0] req_val_y,
   input  logic signed [15:0] req_val_z,
   input  logic [1:0]         req_accuracy,
   input  logic [31:0]        req_now_ms,
   input  logic               req_gps_fix_valid,
   input  logic [31:0]        req_gps_last_fix_ms,
   input  logic [15:0]        req_gps_speed,
   input  logic [15:0]        req_gps_course,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll,
   output logic signed [14:0] rsp_pitch,
   output logic [15:0]        rsp_yaw,
   output logic signed [15:0] rsp_gyro_x,
   output logic signed [15:0] rsp_gyro_y,
   output logic signed [15:0] rsp_gyro_z,
   output logic signed [15:0] rsp_accel_x,
   output logic signed [15:0] rsp_accel_y,
   output logic signed [15:0] rsp_accel_z,
   output logic [1:0]         rsp_quat_accuracy,
   output logic [31:0]        rsp_stamp_ms,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

`include "quaternion_attitude_yaw_fusion_unit_defines.svh"

   localparam logic signed [31:0] GYRO_SCALE = 32'sd37549362;  // 1800/pi in Q16
   localparam logic signed [31:0] RND_SCALE  = 32'sd5368710;   // 2^29/100, rounded up
   localparam logic signed [31:0] GAIN_RECIP = 32'sd1431655;   // 2^32/3000, rounded down
   localparam logic signed [31:0] GAIN_DIV   = 32'sd3000;
   localparam logic signed [39:0] ONE_Q28    = 40'sd268435456;

   function automatic logic signed [63:0] round_shift(input logic signed [63:0] n,
                                                      input int unsigned sh);
      logic signed [63:0] half;
      logic signed [63:0] res;
      half = 64'sd1 <<< (sh - 1);
      if (n >= 0) res = (n + half) >>> sh;
      else        res = -((-n + half) >>> sh);
      return res;
   endfunction

   // configuration
   logic [15:0] cfg_period_ff, cfg_max_age_ff, cfg_min_speed_ff;
   logic [14:0] cfg_deadband_ff;
   logic [15:0] cfg_gain_min_ff, cfg_gain_max_ff;
   logic        csr_write;
   qayf_pkg::csr_index_type csr_index;

   // control
   qayf_pkg::state_type state_ff, state_in;
   qayf_pkg::angle_type angle_sel_ff;
   logic [3:0]          cnt_ff;
   logic                req_accept, period_ok, gps_ok, emit_ok;
   logic                rsp_valid_ff;

   // latched word
   logic signed [15:0] q_w_ff, q_x_ff, q_y_ff, q_z_ff;
   logic [1:0]         accuracy_ff;
   logic [31:0]        now_ff, fix_ms_ff;
   logic               fix_valid_ff;
   logic [15:0]        speed_ff, course_ff;

   // state
   logic signed [15:0] gyro_ff [3];
   logic signed [15:0] accel_ff [3];
   logic [31:0]        last_ff;

   // shared multiplier
   logic signed [31:0] ma, mb;
   logic signed [63:0] mul_ff;

   // working values
   logic signed [33:0] acc_ry_ff, acc_rx_ff, acc_s_ff, acc_yy_ff, acc_yx_ff;
   logic signed [33:0] prod;
   logic signed [29:0] s_ff, s_clamp;
   logic signed [34:0] s_full;
   logic signed [15:0] roll_ff;
   logic signed [14:0] pitch_ff;
   logic [15:0]        yaw_ff;
   logic [20:0]        q0_ff;
   logic [15:0]        gain_ff, gain_next;
   logic signed [15:0] delta_ff, delta_next;
   logic [15:0]        delta_mag;
   logic [1:0]         gyro_idx;

   // unit hookup
   logic                              cordic_start, cordic_done;
   logic signed [qayf_pkg::VEC_W-1:0] vec_y, vec_x;
   logic signed [qayf_pkg::ANGLE_W-1:0] cordic_angle;
   logic                              sqrt_start, sqrt_done;
   logic [qayf_pkg::SQRT_IN_W-1:0]    radicand;
   logic [qayf_pkg::SQRT_OUT_W-1:0]   sqrt_root;

   // angle rounding
   logic [15:0]        rnd_q;
   logic signed [16:0] rnd_val, rnd_lim, rnd_clamped, rnd_wrapped;

   // heading correction
   logic [32:0]        gain_rem;
   logic [21:0]        gain_raw;
   logic signed [17:0] diff, diff1, corr_sum;
   logic signed [16:0] corr;

   qayf_cordic #(
      .ITERATIONS (ANGLE_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .vec_y  (vec_y),
      .vec_x  (vec_x),
      .done   (cordic_done),
      .angle  (cordic_angle)
   );

   qayf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_stall  = (state_ff != qayf_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign period_ok  = ((req_now_ms - last_ff) >= {16'h0, cfg_period_ff});
   assign gps_ok     = fix_valid_ff && (fix_ms_ff != 32'h0) &&
                       ((now_ff - fix_ms_ff) < {16'h0, cfg_max_age_ff}) &&
                       (speed_ff >= cfg_min_speed_ff);
   assign emit_ok    = !rsp_valid_ff || !rsp_stall;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = qayf_pkg::csr_index_type'(paddr[4:2]);
   assign pready    = 1'b1;

   always_comb begin
      unique case (csr_index)
         qayf_pkg::CSR_PERIOD:    prdata = {16'h0, cfg_period_ff};
         qayf_pkg::CSR_MAX_AGE:   prdata = {16'h0, cfg_max_age_ff};
         qayf_pkg::CSR_MIN_SPEED: prdata = {16'h0, cfg_min_speed_ff};
         qayf_pkg::CSR_DEADBAND:  prdata = {17'h0, cfg_deadband_ff};
         qayf_pkg::CSR_GAIN_MIN:  prdata = {16'h0, cfg_gain_min_ff};
         qayf_pkg::CSR_GAIN_MAX:  prdata = {16'h0, cfg_gain_max_ff};
         default:                 prdata = 32'h0;
      endcase
   end

   // quaternion terms and pitch operand
   assign prod   = mul_ff[33:0];
   assign s_full = {acc_s_ff, 1'b0};
   always_comb begin
      if (s_full > 35'sd268435456)       s_clamp = 30'sd268435456;
      else if (s_full < -35'sd268435456) s_clamp = -30'sd268435456;
      else                               s_clamp = 30'(s_full);
   end
   assign radicand = (58'd1 << 56) - mul_ff[57:0];

   always_comb begin
      unique case (angle_sel_ff)
         qayf_pkg::ANG_ROLL: begin
            vec_y = {{5{acc_ry_ff[33]}}, acc_ry_ff, 1'b0};
            vec_x = ONE_Q28 - {{5{acc_rx_ff[33]}}, acc_rx_ff, 1'b0};
         end
         qayf_pkg::ANG_PITCH: begin
            vec_y = {{10{s_ff[29]}}, s_ff};
            vec_x = {11'h0, sqrt_root};
         end
         qayf_pkg::ANG_YAW: begin
            vec_y = {{5{acc_yy_ff[33]}}, acc_yy_ff, 1'b0};
            vec_x = ONE_Q28 - {{5{acc_yx_ff[33]}}, acc_yx_ff, 1'b0};
         end
         default: begin
            vec_y = '0;
            vec_x = '0;
         end
      endcase
   end

   // round 1e-4 degree to 0.01 degree, clamp, wrap yaw
   assign rnd_q   = mul_ff[44:29];
   assign rnd_val = cordic_angle[qayf_pkg::ANGLE_W-1] ? -$signed({1'b0, rnd_q})
                                                       : $signed({1'b0, rnd_q});
   assign rnd_lim = (angle_sel_ff == qayf_pkg::ANG_PITCH) ? 17'sd9000 : 17'sd18000;
   always_comb begin
      if (rnd_val > rnd_lim)       rnd_clamped = rnd_lim;
      else if (rnd_val < -rnd_lim) rnd_clamped = -rnd_lim;
      else                         rnd_clamped = rnd_val;
   end
   assign rnd_wrapped = (rnd_clamped < 0) ? rnd_clamped + 17'sd36000 : rnd_clamped;

   // heading error wrapped into half a turn
   assign diff  = $signed({2'b00, course_ff}) - $signed({2'b00, yaw_ff});
   always_comb begin
      if (diff > 18'sd18000)       diff1 = diff - 18'sd36000;
      else if (diff < -18'sd18000) diff1 = diff + 18'sd36000;
      else                         diff1 = diff;
      delta_next = (diff1 > 18'sd18000) ? 16'(diff1 - 18'sd36000) : 16'(diff1);
   end
   assign delta_mag = (delta_ff < 0) ? 16'(-delta_ff) : 16'(delta_ff);

   // gain = floor(speed * 65536 / 3000), then clamp
   assign gain_rem = {1'b0, speed_ff, 16'h0} - mul_ff[32:0];
   assign gain_raw = 22'(q0_ff) + ((gain_rem >= 33'd3000) ? 22'd1 : 22'd0);
   always_comb begin
      if (gain_raw < 22'(cfg_gain_min_ff))      gain_next = cfg_gain_min_ff;
      else if (gain_raw > 22'(cfg_gain_max_ff)) gain_next = cfg_gain_max_ff;
      else                                      gain_next = gain_raw[15:0];
   end

   assign corr     = 17'(round_shift(mul_ff, 16));
   assign corr_sum = $signed({2'b00, yaw_ff}) + 18'(corr);

   assign gyro_idx = 2'(cnt_ff - 4'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qayf_pkg::S_IDLE: begin
            if (req_accept) begin
               if (req_op == qayf_pkg::OP_GYRO) state_in = qayf_pkg::S_GYRO;
               else if (req_op == qayf_pkg::OP_QUAT && period_ok) state_in = qayf_pkg::S_PROD;
            end
         end
         qayf_pkg::S_GYRO:      if (cnt_ff == 4'd3) state_in = qayf_pkg::S_IDLE;
         qayf_pkg::S_PROD:      if (cnt_ff == 4'd9) state_in = qayf_pkg::S_SQMUL;
         qayf_pkg::S_SQMUL:     state_in = qayf_pkg::S_SQSTART;
         qayf_pkg::S_SQSTART:   state_in = qayf_pkg::S_SQWAIT;
         qayf_pkg::S_SQWAIT:    if (sqrt_done) state_in = qayf_pkg::S_ANG_START;
         qayf_pkg::S_ANG_START: state_in = qayf_pkg::S_ANG_WAIT;
         qayf_pkg::S_ANG_WAIT:  if (cordic_done) state_in = qayf_pkg::S_ANG_MUL;
         qayf_pkg::S_ANG_MUL:   state_in = qayf_pkg::S_ANG_RND;
         qayf_pkg::S_ANG_RND: begin
            if (angle_sel_ff != qayf_pkg::ANG_YAW) state_in = qayf_pkg::S_ANG_START;
            else if (gps_ok)                       state_in = qayf_pkg::S_GAIN_MUL;
            else                                   state_in = qayf_pkg::S_EMIT;
         end
         qayf_pkg::S_GAIN_MUL:  state_in = qayf_pkg::S_GAIN_Q;
         qayf_pkg::S_GAIN_Q:    state_in = qayf_pkg::S_GAIN_CLAMP;
         qayf_pkg::S_GAIN_CLAMP: begin
            if (delta_mag > {1'b0, cfg_deadband_ff}) state_in = qayf_pkg::S_CORR_MUL;
            else                                     state_in = qayf_pkg::S_EMIT;
         end
         qayf_pkg::S_CORR_MUL:  state_in = qayf_pkg::S_CORR;
         qayf_pkg::S_CORR:      state_in = qayf_pkg::S_EMIT;
         qayf_pkg::S_EMIT:      if (emit_ok) state_in = qayf_pkg::S_IDLE;
         default:               state_in = qayf_pkg::S_IDLE;
      endcase
   end

   // multiplier operands and unit starts
   always_comb begin
      ma           = '0;
      mb           = '0;
      sqrt_start   = 1'b0;
      cordic_start = 1'b0;
      unique case (state_ff)
         qayf_pkg::S_GYRO: begin
            mb = GYRO_SCALE;
            unique case (cnt_ff)
               4'd0:    ma = 32'(q_x_ff);
               4'd1:    ma = 32'(q_y_ff);
               4'd2:    ma = 32'(q_z_ff);
               default: ma = '0;
            endcase
         end
         qayf_pkg::S_PROD: begin
            unique case (cnt_ff)
               4'd0: begin ma = 32'(q_w_ff); mb = 32'(q_x_ff); end
               4'd1: begin ma = 32'(q_y_ff); mb = 32'(q_z_ff); end
               4'd2: begin ma = 32'(q_x_ff); mb = 32'(q_x_ff); end
               4'd3: begin ma = 32'(q_y_ff); mb = 32'(q_y_ff); end
               4'd4: begin ma = 32'(q_w_ff); mb = 32'(q_y_ff); end
               4'd5: begin ma = 32'(q_z_ff); mb = 32'(q_x_ff); end
               4'd6: begin ma = 32'(q_w_ff); mb = 32'(q_z_ff); end
               4'd7: begin ma = 32'(q_x_ff); mb = 32'(q_y_ff); end
               4'd8: begin ma = 32'(q_z_ff); mb = 32'(q_z_ff); end
               default: begin ma = '0; mb = '0; end
            endcase
         end
         qayf_pkg::S_SQMUL: begin
            ma = 32'(s_clamp);
            mb = 32'(s_clamp);
         end
         qayf_pkg::S_SQSTART:   sqrt_start = 1'b1;
         qayf_pkg::S_ANG_START: cordic_start = 1'b1;
         qayf_pkg::S_ANG_MUL: begin
            ma = cordic_angle[qayf_pkg::ANGLE_W-1] ? 32'(-cordic_angle) + 32'sd50
                                                   : 32'(cordic_angle) + 32'sd50;
            mb = RND_SCALE;
         end
         qayf_pkg::S_GAIN_MUL: begin
            ma = $signed({16'h0, speed_ff});
            mb = GAIN_RECIP;
         end
         qayf_pkg::S_GAIN_Q: begin
            ma = $signed({11'h0, mul_ff[36:16]});
            mb = GAIN_DIV;
         end
         qayf_pkg::S_CORR_MUL: begin
            ma = 32'(delta_ff);
            mb = $signed({16'h0, gain_ff});
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= 64'(ma) * 64'(mb);
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= qayf_pkg::S_IDLE;
         angle_sel_ff     <= qayf_pkg::ANG_ROLL;
         cnt_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         last_ff          <= '0;
         cfg_period_ff    <= qayf_pkg::PERIOD_RESET;
         cfg_max_age_ff   <= qayf_pkg::MAX_AGE_RESET;
         cfg_min_speed_ff <= qayf_pkg::MIN_SPEED_RESET;
         cfg_deadband_ff  <= qayf_pkg::DEADBAND_RESET;
         cfg_gain_min_ff  <= qayf_pkg::GAIN_MIN_RESET;
         cfg_gain_max_ff  <= qayf_pkg::GAIN_MAX_RESET;
         for (int i = 0; i < 3; i++) begin
            gyro_ff[i]  <= '0;
            accel_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (state_ff == qayf_pkg::S_GYRO || state_ff == qayf_pkg::S_PROD) begin
            cnt_ff <= cnt_ff + 4'd1;
         end else begin
            cnt_ff <= '0;
         end

         if (state_ff == qayf_pkg::S_SQWAIT) begin
            angle_sel_ff <= qayf_pkg::ANG_ROLL;
         end else if (state_ff == qayf_pkg::S_ANG_RND) begin
            unique case (angle_sel_ff)
               qayf_pkg::ANG_ROLL:  angle_sel_ff <= qayf_pkg::ANG_PITCH;
               qayf_pkg::ANG_PITCH: angle_sel_ff <= qayf_pkg::ANG_YAW;
               default:             angle_sel_ff <= qayf_pkg::ANG_ROLL;
            endcase
         end

         if (req_accept) begin
            if (req_op == qayf_pkg::OP_ACCEL) begin
               accel_ff[0] <= req_val_x;
               accel_ff[1] <= req_val_y;
               accel_ff[2] <= req_val_z;
            end
            if (req_op == qayf_pkg::OP_QUAT && period_ok) last_ff <= req_now_ms;
         end

         if (state_ff == qayf_pkg::S_GYRO && cnt_ff != 4'd0) begin
            gyro_ff[gyro_idx] <= 16'(round_shift(mul_ff, 26));
         end

         if (state_ff == qayf_pkg::S_EMIT && emit_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write) begin
            unique case (csr_index)
               qayf_pkg::CSR_PERIOD:    cfg_period_ff    <= pwdata[15:0];
               qayf_pkg::CSR_MAX_AGE:   cfg_max_age_ff   <= pwdata[15:0];
               qayf_pkg::CSR_MIN_SPEED: cfg_min_speed_ff <= pwdata[15:0];
               qayf_pkg::CSR_DEADBAND:  cfg_deadband_ff  <= pwdata[14:0];
               qayf_pkg::CSR_GAIN_MIN:  cfg_gain_min_ff  <= pwdata[15:0];
               qayf_pkg::CSR_GAIN_MAX:  cfg_gain_max_ff  <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         q_w_ff       <= req_val_w;
         q_x_ff       <= req_val_x;
         q_y_ff       <= req_val_y;
         q_z_ff       <= req_val_z;
         accuracy_ff  <= req_accuracy;
         now_ff       <= req_now_ms;
         fix_valid_ff <= req_gps_fix_valid;
         fix_ms_ff    <= req_gps_last_fix_ms;
         speed_ff     <= req_gps_speed;
         course_ff    <= req_gps_course;
      end

      if (state_ff == qayf_pkg::S_PROD) begin
         unique case (cnt_ff)
            4'd1: acc_ry_ff <= prod;
            4'd2: acc_ry_ff <= acc_ry_ff + prod;
            4'd3: acc_rx_ff <= prod;
            4'd4: begin
               acc_rx_ff <= acc_rx_ff + prod;
               acc_yx_ff <= prod;
            end
            4'd5: acc_s_ff  <= prod;
            4'd6: acc_s_ff  <= acc_s_ff - prod;
            4'd7: acc_yy_ff <= prod;
            4'd8: acc_yy_ff <= acc_yy_ff + prod;
            4'd9: acc_yx_ff <= acc_yx_ff + prod;
            default: ;
         endcase
      end

      if (state_ff == qayf_pkg::S_SQMUL) s_ff <= s_clamp;

      if (state_ff == qayf_pkg::S_ANG_RND) begin
         unique case (angle_sel_ff)
            qayf_pkg::ANG_ROLL:  roll_ff  <= 16'(rnd_clamped);
            qayf_pkg::ANG_PITCH: pitch_ff <= 15'(rnd_clamped);
            qayf_pkg::ANG_YAW:   yaw_ff   <= 16'(rnd_wrapped);
            default: ;
         endcase
      end

      if (state_ff == qayf_pkg::S_GAIN_MUL)   delta_ff <= delta_next;
      if (state_ff == qayf_pkg::S_GAIN_Q)     q0_ff    <= mul_ff[36:16];
      if (state_ff == qayf_pkg::S_GAIN_CLAMP) gain_ff  <= gain_next;

      if (state_ff == qayf_pkg::S_CORR) begin
         if (corr_sum < 0)                yaw_ff <= 16'(corr_sum + 18'sd36000);
         else if (corr_sum >= 18'sd36000) yaw_ff <= 16'(corr_sum - 18'sd36000);
         else                             yaw_ff <= 16'(corr_sum);
      end

      if (state_ff == qayf_pkg::S_EMIT && emit_ok) begin
         rsp_roll          <= roll_ff;
         rsp_pitch         <= pitch_ff;
         rsp_yaw           <= yaw_ff;
         rsp_gyro_x        <= gyro_ff[0];
         rsp_gyro_y        <= gyro_ff[1];
         rsp_gyro_z        <= gyro_ff[2];
         rsp_accel_x       <= accel_ff[0];
         rsp_accel_y       <= accel_ff[1];
         rsp_accel_z       <= accel_ff[2];
         rsp_quat_accuracy <= accuracy_ff;
         rsp_stamp_ms      <= now_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `QAYF_ASSERT_SAME(a_cordic_done_in_wait, cordic_done, state_ff == qayf_pkg::S_ANG_WAIT)
   `QAYF_ASSERT_SAME(a_sqrt_done_in_wait, sqrt_done, state_ff == qayf_pkg::S_SQWAIT)
   `QAYF_ASSERT_NEXT(a_emit_loads_word, (state_ff == qayf_pkg::S_EMIT) && !rsp_valid_ff, rsp_valid_ff)

endmodule

`default_nettype wire
